// ===== rtl/core/srodo_pkg.sv =====
package srodo_pkg;

	// Default sizes for the top-level parameters
	localparam int MAX_REELS_DEF  = 8;
	localparam int PULSE_BITS_DEF = 16;

	// Port widths fixed by the item format
	localparam int REQ_W       = 3;
	localparam int VALUE_W     = 32;
	localparam int REEL_NUM_W  = 8;
	localparam int PULSE_CNT_W = 16;
	localparam int SHOWN_W     = 32;
	localparam int DIGIT_W     = 4;
	localparam int STEPS_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_TICK = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADD  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ZERO = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SPIN = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_RANGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REEL_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_STEPS = 2'd2;

	// Configuration reset values
	localparam logic [DIGIT_W-1:0] DIGIT_RANGE_RST = 4'd9;
	localparam logic [DIGIT_W-1:0] REEL_COUNT_RST  = 4'd5;
	localparam logic [STEPS_W-1:0] MOTOR_STEPS_RST = 8'd2;

endpackage

// ===== rtl/core/score_reel_odometer_controller.sv =====
// Score reel odometer controller.
// Input channel (in_valid/in_ready) takes one request item: tick, add value,
// set value, roll to zero, or spin one reel. Output channel (out_valid/
// out_ready) returns exactly one result item per request. The config channel
// (cfg_valid/cfg_ready, always ready) writes digit_range, reel_count and
// motor_steps; write it only while no request is in flight.
// The sequencer visits one reel per cycle, save while the divider runs,
// through a single saturating pulse adder. A tick, roll to zero or set visits
// every reel in use, a spin to a reel in use only that reel, and an add of
// zero ends at its first step; an undefined request, a spin out of range or
// any request with no reels in use goes straight to finish. Add and set run a
// shared restoring divider, one quotient bit per cycle, for each reel still
// reached by a nonzero value, and an add spends one more step to see the
// value run out.
// The block takes one request at a time; in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next request is taken while that result waits; if the receiver still
// stalls when the next result is done, the sequencer holds until it drains.
// Reset clears all reel digits, pending pulses and countdowns and loads the
// configuration defaults (range 9, five reels, two motor steps).
module score_reel_odometer_controller #(
	parameter int MAX_REELS  = srodo_pkg::MAX_REELS_DEF,
	parameter int PULSE_BITS = srodo_pkg::PULSE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [srodo_pkg::REQ_W-1:0]           req_type,
	input  logic signed [srodo_pkg::VALUE_W-1:0]  value,
	input  logic [srodo_pkg::REEL_NUM_W-1:0]      reel_number,
	input  logic signed [srodo_pkg::PULSE_CNT_W-1:0] pulse_count,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  status,
	output logic                                  animated,
	output logic                                  click,
	output logic                                  busy_res,
	output logic [srodo_pkg::SHOWN_W-1:0]         shown_digits,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [srodo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srodo_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DW   = srodo_pkg::DIGIT_W;
	localparam int TW   = srodo_pkg::STEPS_W;
	localparam int VW   = srodo_pkg::VALUE_W;
	localparam int PCW  = srodo_pkg::PULSE_CNT_W;
	localparam int RNW  = srodo_pkg::REEL_NUM_W;
	localparam int RW   = (MAX_REELS > 1) ? $clog2(MAX_REELS) : 1;
	localparam int NW   = $clog2(MAX_REELS + 1);
	localparam int SW   = ((PULSE_BITS > PCW) ? PULSE_BITS : PCW) + 1;
	localparam int SHW  = (4 * MAX_REELS > srodo_pkg::SHOWN_W) ?
		4 * MAX_REELS : srodo_pkg::SHOWN_W;
	localparam int CW   = $clog2(VW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic signed [SW-1:0] PMAX =
		{{(SW - PULSE_BITS + 1){1'b0}}, {(PULSE_BITS - 1){1'b1}}};
	localparam logic signed [SW-1:0] PMIN =
		{{(SW - PULSE_BITS + 1){1'b1}}, {(PULSE_BITS - 1){1'b0}}};
	localparam logic [CW-1:0] DIV_FIRST = CW'(VW - 1);

	// Configuration registers
	logic [DW-1:0] range_cfg_q;
	logic [DW-1:0] count_cfg_q;
	logic [TW-1:0] steps_cfg_q;

	// Reel state
	logic [DW-1:0]                digit_q [MAX_REELS];
	logic signed [PULSE_BITS-1:0] pend_q  [MAX_REELS];
	logic [TW-1:0]                cd_q    [MAX_REELS];

	// Sequencer and item registers
	logic [1:0]              st_q;
	logic [srodo_pkg::REQ_W-1:0] op_q;
	logic [VW-1:0]           v_q;
	logic                    neg_q;
	logic signed [PCW-1:0]   pc_q;
	logic [NW-1:0]           n_q;
	logic [DW-1:0]           range_q;
	logic [TW-1:0]           steps_q;
	logic [RW-1:0]           idx_q;
	logic signed [1:0]       cin_q;
	logic                    have_rem_q;
	logic [DW-1:0]           rem_q;
	logic [CW-1:0]           div_cnt_q;
	logic                    status_q;
	logic                    anim_q;
	logic                    click_q;

	// Result register
	logic                        out_valid_q;
	logic                        res_status_q;
	logic                        res_anim_q;
	logic                        res_click_q;
	logic                        res_busy_q;
	logic [srodo_pkg::SHOWN_W-1:0] res_shown_q;

	// Accept-time values
	logic [NW:0]     n_wide;
	logic [NW-1:0]   n_now;
	logic [NW-1:0]   n_m1;
	logic [RNW-1:0]  rn_m1;
	logic            spin_ok;
	logic [VW-1:0]   mag_now;
	logic            in_acc;

	// Current reel and shared unit
	logic [DW:0]              base;
	logic [DW-1:0]            cur_d;
	logic signed [PULSE_BITS-1:0] cur_p;
	logic [TW-1:0]            cur_cd;
	logic signed [PULSE_BITS-1:0] add_a;
	logic signed [PCW-1:0]    add_d;
	logic signed [SW-1:0]     add_sum;
	logic signed [PULSE_BITS-1:0] sat_p;
	logic signed [PCW-1:0]    rem_ext;
	logic [DW+1:0]            adj;

	// Step decisions
	logic                     wr_en;
	logic [DW-1:0]            wr_d;
	logic signed [PULSE_BITS-1:0] wr_p;
	logic [TW-1:0]            wr_cd;
	logic signed [1:0]        cout;
	logic                     go_div;
	logic                     last;
	logic                     hit_anim;
	logic                     hit_click;
	logic                     start;
	logic [TW-1:0]            cd1;
	logic [TW-1:0]            cd2;

	// Divider step
	logic [DW:0]              div_t;
	logic                     div_ge;
	logic [DW:0]              div_r;

	// Summary
	logic                     busy_now;
	logic [SHW-1:0]           all_dig;
	logic [SHW-1:0]           shifted;
	logic [NW-1:0]            gap;
	logic                     out_free;

	assign in_ready     = (st_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign status       = res_status_q;
	assign animated     = res_anim_q;
	assign click        = res_click_q;
	assign busy_res     = res_busy_q;
	assign shown_digits = res_shown_q;
	assign in_acc       = in_valid && in_ready;
	assign out_free     = !out_valid_q || out_ready;

	// Clamp reel count and check the spin target
	always_comb begin
		n_wide  = ({1'b0, count_cfg_q} > 5'(MAX_REELS)) ? (NW + 1)'(MAX_REELS)
			: (NW + 1)'(count_cfg_q);
		n_now   = n_wide[NW-1:0];
		n_m1    = n_now - 1'b1;
		rn_m1   = reel_number - 1'b1;
		spin_ok = (reel_number != '0) && (reel_number <= RNW'(n_now));
		mag_now = value[VW-1] ? (VW'(0) - value) : value;
	end

	// Read the current reel and run the saturating pulse adder
	always_comb begin
		base    = {1'b0, range_q} + 1'b1;
		cur_d   = digit_q[idx_q];
		cur_p   = pend_q[idx_q];
		cur_cd  = cd_q[idx_q];
		rem_ext = {{(PCW - DW){1'b0}}, rem_q};
		adj     = (DW + 2)'(base) - (DW + 2)'(cin_q[0]) - (DW + 2)'(cur_d);
		add_a   = cur_p;
		add_d   = '0;
		case (op_q)
			srodo_pkg::REQ_TICK: add_d = {{(PCW - 2){cin_q[1]}}, cin_q};
			srodo_pkg::REQ_ADD:  add_d = neg_q ? (PCW'(0) - rem_ext) : rem_ext;
			srodo_pkg::REQ_ZERO: begin
				add_a = '0;
				add_d = {{(PCW - DW - 2){adj[DW+1]}}, adj};
			end
			srodo_pkg::REQ_SPIN: add_d = pc_q;
			default:             add_d = '0;
		endcase
		add_sum = {{(SW - PULSE_BITS){add_a[PULSE_BITS-1]}}, add_a}
			+ {{(SW - PCW){add_d[PCW-1]}}, add_d};
		if (add_sum > PMAX) begin
			sat_p = PMAX[PULSE_BITS-1:0];
		end else if (add_sum < PMIN) begin
			sat_p = PMIN[PULSE_BITS-1:0];
		end else begin
			sat_p = add_sum[PULSE_BITS-1:0];
		end
	end

	// Decide what one sequencer step does to the current reel
	always_comb begin
		wr_en     = 1'b0;
		wr_d      = cur_d;
		wr_p      = cur_p;
		wr_cd     = cur_cd;
		cout      = 2'sb00;
		go_div    = 1'b0;
		last      = (idx_q == '0);
		hit_anim  = 1'b0;
		hit_click = 1'b0;
		start     = (sat_p != '0) && (cur_cd == '0);
		cd1       = start ? steps_q : cur_cd;
		cd2       = (cd1 != '0) ? (cd1 - 1'b1) : cd1;
		case (op_q)
			srodo_pkg::REQ_TICK: begin
				wr_en     = 1'b1;
				wr_p      = sat_p;
				wr_cd     = cd2;
				hit_click = start;
				hit_anim  = (cd1 != '0);
				if ((cd1 != '0) && (cd2 == '0)) begin
					if (sat_p[PULSE_BITS-1]) begin
						wr_p = sat_p + 1'b1;
						if (cur_d == '0) begin
							wr_d = range_q;
							cout = 2'sb11;
						end else begin
							wr_d = cur_d - 1'b1;
						end
					end else begin
						wr_p = sat_p - 1'b1;
						if (cur_d >= range_q) begin
							wr_d = cur_d - range_q;
							cout = 2'sb01;
						end else begin
							wr_d = cur_d + 1'b1;
						end
					end
				end
			end
			srodo_pkg::REQ_ADD: begin
				if (v_q == '0 && !have_rem_q) begin
					last = 1'b1;
				end else if (!have_rem_q) begin
					go_div = 1'b1;
				end else begin
					wr_en = 1'b1;
					wr_p  = sat_p;
				end
			end
			srodo_pkg::REQ_SET: begin
				if (v_q != '0 && !have_rem_q) begin
					go_div = 1'b1;
				end else begin
					wr_en = 1'b1;
					wr_d  = have_rem_q ? rem_q : '0;
					wr_p  = '0;
					wr_cd = '0;
				end
			end
			srodo_pkg::REQ_ZERO: begin
				if (cin_q != 2'sb00 || cur_d != '0) begin
					wr_en = 1'b1;
					wr_p  = sat_p;
					cout  = 2'sb01;
				end
			end
			srodo_pkg::REQ_SPIN: begin
				wr_en = 1'b1;
				wr_p  = sat_p;
				last  = 1'b1;
			end
			default: last = 1'b1;
		endcase
	end

	// One restoring division step by the base
	always_comb begin
		div_t  = {rem_q, v_q[VW-1]};
		div_ge = (div_t >= base);
		div_r  = div_ge ? (div_t - base) : div_t;
	end

	// Summarize reels in use for the result
	always_comb begin
		busy_now = 1'b0;
		all_dig  = '0;
		for (int i = 0; i < MAX_REELS; i++) begin
			if ((NW'(i) < n_q) && (pend_q[i] != '0 || cd_q[i] != '0)) begin
				busy_now = 1'b1;
			end
			all_dig[4 * (MAX_REELS - 1 - i) +: 4] = digit_q[i];
		end
		gap     = NW'(MAX_REELS) - n_q;
		shifted = all_dig >> {gap, 2'b00};
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_cfg_q <= srodo_pkg::DIGIT_RANGE_RST;
			count_cfg_q <= srodo_pkg::REEL_COUNT_RST;
			steps_cfg_q <= srodo_pkg::MOTOR_STEPS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				srodo_pkg::REG_DIGIT_RANGE: range_cfg_q <= cfg_data[DW-1:0];
				srodo_pkg::REG_REEL_COUNT:  count_cfg_q <= cfg_data[DW-1:0];
				srodo_pkg::REG_MOTOR_STEPS: steps_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Update the reel selected by the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_REELS; i++) begin
				digit_q[i] <= '0;
				pend_q[i]  <= '0;
				cd_q[i]    <= '0;
			end
		end else if (st_q == ST_STEP && wr_en) begin
			digit_q[idx_q] <= wr_d;
			pend_q[idx_q]  <= wr_p;
			cd_q[idx_q]    <= wr_cd;
		end
	end

	// Sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			have_rem_q <= 1'b0;
			n_q        <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q       <= req_type;
						v_q        <= mag_now;
						neg_q      <= value[VW-1];
						pc_q       <= pulse_count;
						n_q        <= n_now;
						range_q    <= range_cfg_q;
						steps_q    <= (steps_cfg_q == '0) ? TW'(1) : steps_cfg_q;
						idx_q      <= n_m1[RW-1:0];
						cin_q      <= 2'sb00;
						have_rem_q <= 1'b0;
						status_q   <= 1'b0;
						anim_q     <= 1'b0;
						click_q    <= 1'b0;
						if (req_type > srodo_pkg::REQ_SPIN) begin
							st_q <= ST_FIN;
						end else if (req_type == srodo_pkg::REQ_SPIN) begin
							// A spin with no reels in use is out of range too
							idx_q <= rn_m1[RW-1:0];
							if (spin_ok) begin
								st_q <= ST_STEP;
							end else begin
								status_q <= 1'b1;
								st_q     <= ST_FIN;
							end
						end else if (n_now == '0) begin
							st_q <= ST_FIN;
						end else begin
							st_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					if (go_div) begin
						rem_q     <= '0;
						div_cnt_q <= DIV_FIRST;
						st_q      <= ST_DIV;
					end else begin
						have_rem_q <= 1'b0;
						cin_q      <= cout;
						anim_q     <= anim_q | hit_anim;
						click_q    <= click_q | hit_click;
						if (last) begin
							st_q <= ST_FIN;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				ST_DIV: begin
					v_q       <= {v_q[VW-2:0], div_ge};
					rem_q     <= div_r[DW-1:0];
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						have_rem_q <= 1'b1;
						st_q       <= ST_STEP;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Load the result register and drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_FIN && out_free) begin
			out_valid_q  <= 1'b1;
			res_status_q <= status_q;
			res_anim_q   <= anim_q;
			res_click_q  <= click_q;
			res_busy_q   <= busy_now;
			res_shown_q  <= shifted[srodo_pkg::SHOWN_W-1:0];
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	a_reel_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_STEP |-> NW'(idx_q) < n_q)
		else $error("sequencer visits a reel outside those in use");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		have_rem_q |-> {1'b0, rem_q} < base)
		else $error("divider remainder not below the base");

	a_result_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN && out_free |=> out_valid)
		else $error("finished request gave no result");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import srodo_pkg::*;

	localparam int REELS = MAX_REELS_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES = 250;
	localparam int ITEMS_PER_PHASE = 125;
	localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

	typedef struct {
		logic        status;
		logic        animated;
		logic        click;
		logic        busy;
		logic [31:0] shown;
	} reel_result_t;

	// Mirror of the reel row: predicts one result item per request item
	class reel_scoreboard;
		logic [3:0]         digit_range;
		logic [3:0]         reel_count;
		logic [7:0]         motor_steps;
		logic [3:0]         reel_digit [REELS];
		logic signed [15:0] pending [REELS];
		logic [7:0]         countdown [REELS];
		reel_result_t       expected_q [$];
		int                 mismatches;

		function new();
			mismatches = 0;
			digit_range = DIGIT_RANGE_RST;
			reel_count = REEL_COUNT_RST;
			motor_steps = MOTOR_STEPS_RST;
			for (int i = 0; i < REELS; i++) begin
				reel_digit[i] = 0;
				pending[i] = 0;
				countdown[i] = 0;
			end
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx,
				logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DIGIT_RANGE: digit_range = data[3:0];
				REG_REEL_COUNT:  reel_count = data[3:0];
				REG_MOTOR_STEPS: motor_steps = data;
				default: ;
			endcase
		endfunction

		function int reels_in_use();
			return (reel_count > REELS) ? REELS : int'(reel_count);
		endfunction

		// Add to a pending count, saturating at the signed pulse range
		function void bump_pending(int r, longint delta);
			longint v;
			longint hi;
			hi = (longint'(1) << (PULSE_BITS_DEF - 1)) - 1;
			v = longint'(pending[r]) + delta;
			if (v > hi) v = hi;
			if (v < -hi - 1) v = -hi - 1;
			pending[r] = v[15:0];
		endfunction

		function longint unsigned magnitude(logic [31:0] v);
			longint unsigned m;
			m = {32'h0, v};
			if (v[31]) m = 64'h1_0000_0000 - m;
			return m;
		endfunction

		function void note_request(logic [REQ_W-1:0] req, logic signed [31:0] val,
				logic [7:0] rn, logic signed [15:0] pc);
			int n;
			int d;
			longint base;
			longint carry;
			longint adj;
			longint dv;
			longint unsigned mag;
			logic [7:0] steps;
			reel_result_t res;
			n = reels_in_use();
			base = longint'(digit_range) + 1;
			res = '{1'b0, 1'b0, 1'b0, 1'b0, 32'h0};
			case (req)
				REQ_TICK: begin
					steps = (motor_steps == 0) ? 8'd1 : motor_steps;
					// Scan right to left so a carry lands before its reel is visited
					for (int i = n - 1; i >= 0; i--) begin
						if (pending[i] != 0 && countdown[i] == 0) begin
							countdown[i] = steps;
							res.animated = 1'b1;
							res.click = 1'b1;
						end
						if (countdown[i] != 0) begin
							countdown[i] = countdown[i] - 8'd1;
							if (countdown[i] == 0) begin
								d = int'(reel_digit[i]);
								if (pending[i] < 0) begin
									bump_pending(i, 1);
									d--;
									if (d < 0) begin
										d += int'(base);
										if (i != 0) bump_pending(i - 1, -1);
									end
								end else begin
									bump_pending(i, -1);
									d++;
									if (d > int'(digit_range)) begin
										d -= int'(base);
										if (i != 0) bump_pending(i - 1, 1);
									end
								end
								reel_digit[i] = d[3:0];
							end
							res.animated = 1'b1;
						end
					end
				end
				REQ_ADD: begin
					mag = magnitude(val);
					for (int i = n - 1; i >= 0 && mag != 0; i--) begin
						dv = mag % base;
						mag = mag / base;
						bump_pending(i, val[31] ? -dv : dv);
					end
				end
				REQ_SET: begin
					mag = magnitude(val);
					for (int i = 0; i < n; i++) begin
						reel_digit[i] = 0;
						pending[i] = 0;
						countdown[i] = 0;
					end
					for (int i = n - 1; i >= 0 && mag != 0; i--) begin
						dv = mag % base;
						mag = mag / base;
						reel_digit[i] = dv[3:0];
					end
				end
				REQ_ZERO: begin
					carry = 0;
					for (int i = n - 1; i >= 0; i--) begin
						adj = base - carry - longint'(reel_digit[i]);
						carry = 0;
						if (adj != base) begin
							pending[i] = 0;
							bump_pending(i, adj);
							carry = 1;
						end
					end
				end
				REQ_SPIN: begin
					if (rn >= 1 && int'(rn) <= n)
						bump_pending(int'(rn) - 1, longint'(pc));
					else
						res.status = 1'b1;
				end
				default: ;
			endcase
			for (int i = 0; i < n; i++) begin
				if (pending[i] != 0 || countdown[i] != 0) res.busy = 1'b1;
				res.shown[4 * (n - 1 - i) +: 4] = reel_digit[i];
			end
			expected_q.push_back(res);
		endfunction

		function void check_result(reel_result_t got);
			reel_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: shown_digits %h", got.shown);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.animated !== want.animated ||
					got.click !== want.click || got.busy !== want.busy ||
					got.shown !== want.shown) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected st=%b an=%b ck=%b busy=%b digits=%h,",
						" got st=%b an=%b ck=%b busy=%b digits=%h"},
						want.status, want.animated, want.click, want.busy, want.shown,
						got.status, got.animated, got.click, got.busy, got.shown);
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [REQ_W-1:0]        req_type = REQ_TICK;
	logic signed [31:0]      value = '0;
	logic [7:0]              reel_number = '0;
	logic signed [15:0]      pulse_count = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    status;
	logic                    animated;
	logic                    click;
	logic                    busy_res;
	logic [SHOWN_W-1:0]      shown_digits;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_DIGIT_RANGE;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	reel_scoreboard sb = new();

	score_reel_odometer_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.value(value),
		.reel_number(reel_number),
		.pulse_count(pulse_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.animated(animated),
		.click(click),
		.busy_res(busy_res),
		.shown_digits(shown_digits),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Idle at random, then offer one request item and hold it until taken
	task automatic send_request(logic [REQ_W-1:0] req, logic signed [31:0] val,
			logic [7:0] rn, logic signed [15:0] pc);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		value <= val;
		reel_number <= rn;
		pulse_count <= pc;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, val, rn, pc);
	endtask

	// Write one register; the caller drops cfg_valid after the last one
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_register(idx, data);
	endtask

	// Receive result items: check each, stall at random or for a long hold
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{status, animated, click, busy_res, shown_digits});
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
			end
		end
	end

	// Bound the run
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int dr_tab [6];
		int rc_tab [6];
		int ms_tab [6];
		int n;
		int pick;
		logic [3:0] dr;
		logic [3:0] rc;
		logic [7:0] ms;
		logic [REQ_W-1:0] req;
		logic signed [31:0] val;
		logic [7:0] rn;
		logic signed [15:0] pc;

		dr_tab = '{9, 15, 1, 3, 7, 9};
		rc_tab = '{5, 8, 1, 15, 0, 4};
		ms_tab = '{2, 1, 255, 0, 3, 1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset configuration (five reels)
		send_request(REQ_TICK, $urandom, 8'($urandom), 16'($urandom));
		send_request(REQ_UNDEF_LO, $urandom, 8'($urandom), 16'($urandom));
		send_request(REQ_UNDEF_HI, $urandom, 8'($urandom), 16'($urandom));
		send_request(REQ_SPIN, $urandom, 8'd0, 16'sd5);
		send_request(REQ_SPIN, $urandom, 8'd6, 16'sd5);
		send_request(REQ_SPIN, $urandom, 8'd255, -16'sd5);
		// Drive reel one to both saturation limits
		send_request(REQ_SPIN, $urandom, 8'd1, 16'sh7fff);
		send_request(REQ_SPIN, $urandom, 8'd1, 16'sh7fff);
		send_request(REQ_SPIN, $urandom, 8'd1, 16'sh8000);
		send_request(REQ_SPIN, $urandom, 8'd1, 16'sh8000);
		send_request(REQ_SET, 32'sd0, 8'($urandom), 16'($urandom));
		send_request(REQ_SET, 32'sh8000_0000, 8'($urandom), 16'($urandom));
		send_request(REQ_SET, 32'sd12345, 8'($urandom), 16'($urandom));
		send_request(REQ_ADD, 32'sh7fff_ffff, 8'($urandom), 16'($urandom));
		send_request(REQ_ADD, -32'sh7fff_ffff, 8'($urandom), 16'($urandom));
		send_request(REQ_ADD, 32'sd0, 8'($urandom), 16'($urandom));
		send_request(REQ_ADD, 32'sh8000_0000, 8'($urandom), 16'($urandom));
		send_request(REQ_ZERO, $urandom, 8'($urandom), 16'($urandom));
		send_request(REQ_SPIN, $urandom, 8'd5, 16'sd3);
		for (int k = 0; k < 5; k++)
			send_request(REQ_TICK, $urandom, 8'($urandom), 16'($urandom));

		for (int p = 0; p < 8; p++) begin
			// Drain, then reprogram while the block is idle
			in_valid <= 1'b0;
			calm = 1'b0;
			while (sb.expected_q.size() != 0) @(posedge clk);
			if (p < 6) begin
				dr = 4'(dr_tab[p]);
				rc = 4'(rc_tab[p]);
				ms = 8'(ms_tab[p]);
			end else begin
				dr = 4'($urandom_range(0, 15));
				rc = 4'($urandom_range(0, 15));
				ms = 8'($urandom_range(0, 6));
			end
			write_register(REG_DIGIT_RANGE, {4'h0, dr});
			write_register(REG_REEL_COUNT, {4'h0, rc});
			write_register(REG_MOTOR_STEPS, ms);
			cfg_valid <= 1'b0;
			n = (rc > REELS) ? REELS : int'(rc);
			calm = (p == 1);
			if (p == 2 || p == 5) hold_req = 1'b1;

			// Mostly ticks with commands mixed in so reels keep moving
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick = $urandom_range(0, 99);
				val = $urandom;
				rn = 8'($urandom);
				pc = 16'($urandom);
				if (pick < 55) begin
					req = REQ_TICK;
				end else if (pick < 70) begin
					req = REQ_ADD;
					if ($urandom_range(0, 9) < 7) begin
						val = $urandom_range(0, 60);
						if ($urandom_range(0, 1)) val = -val;
					end
				end else if (pick < 77) begin
					req = REQ_SET;
					if ($urandom_range(0, 1)) val = $urandom_range(0, 99999);
				end else if (pick < 82) begin
					req = REQ_ZERO;
				end else if (pick < 95) begin
					req = REQ_SPIN;
					if ($urandom_range(0, 99) < 85)
						rn = 8'($urandom_range(1, (n > 0) ? n : 1));
					if ($urandom_range(0, 99) < 80)
						pc = 16'(int'($urandom_range(0, 30)) - 15);
				end else begin
					req = REQ_W'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
				end
				send_request(req, val, rn, pc);
			end
		end

		// Wait out the last results, then report
		in_valid <= 1'b0;
		calm = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
